FILE: src/tfs_pkg.sv
package tfs_pkg;

    localparam int RAND_W = 30;
    localparam int PORT_W = 16;
    localparam int CNT_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [16:0] PORT_MOD = 17'h0FFFF;
    localparam logic [15:0] MIN_FLOW_SIZE = 16'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMITED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FLOWS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_SIZE     = 3'd5;

    localparam logic [1:0] KIND_SYN  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    typedef struct packed {
        logic              action;
        logic              rate_due;
        logic [RAND_W-1:0] flow_random;
        logic [RAND_W-1:0] sport_random;
        logic [RAND_W-1:0] dport_random;
    } t_in_item;

    typedef struct packed {
        logic              packet_valid;
        logic [1:0]        packet_kind;
        logic [7:0]        flow_index;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [CNT_W-1:0]  sent_count;
        logic              fins_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0]       progress;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } t_flow_entry;

endpackage

FILE: src/tfs_ram.sv
module tfs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/tfs_rem.sv
module tfs_rem #(
    parameter int MAX_FLOWS = 256,
    localparam int CW = $clog2(MAX_FLOWS + 1),
    localparam int IW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tfs_pkg::RAND_W-1:0] i_dividend,
    input  logic [CW-1:0]             i_divisor,
    output logic                      o_done,
    output logic [IW-1:0]             o_rem
);
    import tfs_pkg::*;

    localparam int RW = CW + 1;
    localparam int STEPS = RAND_W / 2;
    localparam int SW = $clog2(STEPS);

    logic [RAND_W-1:0] r_dvd, n_dvd;
    logic [RW-1:0]     r_rem, n_rem;
    logic [CW-1:0]     r_div;
    logic [SW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[RW-2:0], n_dvd[RAND_W-1]};
            n_dvd = {n_dvd[RAND_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_div}) begin
                n_rem = n_rem - {1'b0, r_div};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + SW'(1);
                if (r_cnt == SW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = IW'(r_rem);

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_div}))
        else $error("remainder not below divisor");

endmodule

FILE: src/tcp_flow_traffic_sequencer.sv
// A pull passes through the two-bit-per-cycle flow index remainder, then table read,
// update and output load; the output load waits while an earlier result is not taken.
// A drain pull reads and checks the flows in turn up to the first unfinished one, and
// clear and no-packet items go directly to output load; one item is in work at a time.
// After reset, a clearing pass zeroes the flow table before the first item is accepted;
// configuration writes are taken at any time.
module tcp_flow_traffic_sequencer #(
    parameter int MAX_FLOWS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tfs_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tfs_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tfs_pkg::*;

    localparam int CW = $clog2(MAX_FLOWS + 1);
    localparam int IW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_UPD  = 8'b0001_0000,
        S_SCAN = 8'b0010_0000,
        S_CHK  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    logic        r_active, n_active;
    logic        r_rate_lim, n_rate_lim;
    logic        r_lim_en, n_lim_en;
    logic [31:0] r_limit, n_limit;
    logic [8:0]  r_nflows, n_nflows;
    logic [15:0] r_fsize, n_fsize;

    logic [CNT_W-1:0] r_sent, n_sent;
    logic             r_fins, n_fins;

    logic [PORT_W-1:0] r_sport, n_sport;
    logic [PORT_W-1:0] r_dport, n_dport;
    logic [CW-1:0]     r_n, n_n;
    logic [15:0]       r_size, n_size;

    logic              r_pv, n_pv;
    logic [1:0]        r_kind, n_kind;
    logic [7:0]        r_fidx, n_fidx;
    logic [PORT_W-1:0] r_src, n_src;
    logic [PORT_W-1:0] r_dst, n_dst;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic        in_acc, cfg_acc, limit_hit, sat_full;
    logic [15:0] nf_ext, eff_n16, eff_size, prog_inc;
    logic        div_start, div_done;
    logic [IW-1:0] div_rem;
    logic          ram_we;
    t_flow_entry   ram_wdata, ram_q, ent;
    logic [$bits(t_flow_entry)-1:0] ram_rdata;

    function automatic logic [PORT_W-1:0] port_mod(input logic [RAND_W-1:0] x);
        logic [16:0] s;
        s = 17'(x[RAND_W-1:16]) + 17'(x[15:0]);
        if (s >= PORT_MOD) begin
            s = s - PORT_MOD;
        end
        return PORT_W'(s);
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign limit_hit   = r_lim_en && (r_sent >= r_limit);
    assign sat_full    = (r_sent == '1);

    assign nf_ext   = 16'(r_nflows);
    assign eff_n16  = (nf_ext == 16'd0) ? 16'd1 :
                      (nf_ext > 16'(MAX_FLOWS)) ? 16'(MAX_FLOWS) : nf_ext;
    assign eff_size = (r_fsize < MIN_FLOW_SIZE) ? MIN_FLOW_SIZE : r_fsize;

    assign ram_q = t_flow_entry'(ram_rdata);

    tfs_rem #(.MAX_FLOWS(MAX_FLOWS)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_data.flow_random),
        .i_divisor  (CW'(eff_n16)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    tfs_ram #(.WIDTH($bits(t_flow_entry)), .DEPTH(MAX_FLOWS)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_active    = r_active;
        n_rate_lim  = r_rate_lim;
        n_lim_en    = r_lim_en;
        n_limit     = r_limit;
        n_nflows    = r_nflows;
        n_fsize     = r_fsize;
        n_sent      = r_sent;
        n_fins      = r_fins;
        n_sport     = r_sport;
        n_dport     = r_dport;
        n_n         = r_n;
        n_size      = r_size;
        n_pv        = r_pv;
        n_kind      = r_kind;
        n_fidx      = r_fidx;
        n_src       = r_src;
        n_dst       = r_dst;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        ent         = ram_q;
        prog_inc    = 16'(ram_q.progress + 16'd1);

        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + IW'(1);
                if (r_idx == IW'(MAX_FLOWS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_sport = port_mod(i_in_data.sport_random);
                    n_dport = port_mod(i_in_data.dport_random);
                    n_n     = CW'(eff_n16);
                    n_size  = eff_size;
                    n_pv    = 1'b0;
                    n_kind  = KIND_SYN;
                    n_fidx  = '0;
                    n_src   = '0;
                    n_dst   = '0;
                    if (i_in_data.action) begin
                        n_sent  = '0;
                        n_fins  = 1'b0;
                        n_state = S_EMIT;
                    end else if (!r_active || (limit_hit && r_fins)
                                 || (r_rate_lim && !i_in_data.rate_due)) begin
                        n_state = S_EMIT;
                    end else if (limit_hit) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_idx   = div_rem;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (ram_q.progress == r_size) begin
                    ent.src_port = r_sport;
                    ent.dst_port = r_dport;
                    prog_inc     = 16'd1;
                end
                ent.progress = prog_inc;
                ram_we       = 1'b1;
                ram_wdata    = ent;
                n_pv         = 1'b1;
                if (prog_inc == 16'd1) begin
                    n_kind = KIND_SYN;
                end else if (prog_inc == r_size) begin
                    n_kind = KIND_FIN;
                end else begin
                    n_kind = KIND_DATA;
                end
                n_fidx = 8'(r_idx);
                n_src  = ent.src_port;
                n_dst  = ent.dst_port;
                if (!sat_full) begin
                    n_sent = r_sent + CNT_W'(1);
                end
                n_state = S_EMIT;
            end
            S_SCAN: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (ram_q.progress != r_size) begin
                    ent.progress = r_size;
                    ram_we       = 1'b1;
                    ram_wdata    = ent;
                    n_pv         = 1'b1;
                    n_kind       = KIND_FIN;
                    n_fidx       = 8'(r_idx);
                    n_src        = ram_q.src_port;
                    n_dst        = ram_q.dst_port;
                    if (!sat_full) begin
                        n_sent = r_sent + CNT_W'(1);
                    end
                    n_state = S_EMIT;
                end else if (CW'(r_idx) == r_n - CW'(1)) begin
                    n_fins  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.packet_valid = r_pv;
                    n_out.packet_kind  = r_kind;
                    n_out.flow_index   = r_fidx;
                    n_out.src_port     = r_src;
                    n_out.dst_port     = r_dst;
                    n_out.sent_count   = r_sent;
                    n_out.fins_done    = r_fins;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc) begin
            case (i_cfg_index)
                CFG_ACTIVE: begin
                    n_active = i_cfg_data[0];
                    if (i_cfg_data[0]) begin
                        n_sent = '0;
                        n_fins = 1'b0;
                    end
                end
                CFG_RATE_LIMITED:  n_rate_lim = i_cfg_data[0];
                CFG_LIMIT_ENABLED: n_lim_en   = i_cfg_data[0];
                CFG_PACKET_LIMIT:  n_limit    = i_cfg_data;
                CFG_NUM_FLOWS:     n_nflows   = i_cfg_data[8:0];
                CFG_FLOW_SIZE:     n_fsize    = i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_active    <= 1'b1;
            r_rate_lim  <= 1'b1;
            r_lim_en    <= 1'b0;
            r_limit     <= '0;
            r_nflows    <= 9'd1;
            r_fsize     <= 16'd3;
            r_sent      <= '0;
            r_fins      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_active    <= n_active;
            r_rate_lim  <= n_rate_lim;
            r_lim_en    <= n_lim_en;
            r_limit     <= n_limit;
            r_nflows    <= n_nflows;
            r_fsize     <= n_fsize;
            r_sent      <= n_sent;
            r_fins      <= n_fins;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sport <= n_sport;
        r_dport <= n_dport;
        r_n     <= n_n;
        r_size  <= n_size;
        r_pv    <= n_pv;
        r_kind  <= n_kind;
        r_fidx  <= n_fidx;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sent_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !sat_full && !cfg_acc) |=> (r_sent == $past(r_sent) + CNT_W'(1)))
        else $error("sent count did not advance on a pull");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside the emit state");

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.packet_valid) |-> (r_out.packet_kind == KIND_SYN
            && r_out.flow_index == 8'd0 && r_out.src_port == '0 && r_out.dst_port == '0))
        else $error("result without packet carries packet fields");

endmodule
